@@ rtl/channel_server_lookup_table_assert.svh @@
// Assertion macros shared by the channel server lookup table modules.
// Define ASSERT_OFF to compile every assertion to nothing.
`ifndef CHANNEL_SERVER_LOOKUP_TABLE_ASSERT_SVH
`define CHANNEL_SERVER_LOOKUP_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CSLT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSLT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CSLT_ASSERT(label, clk, rst_n, prop, msg)
`define CSLT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/cslt_pkg.sv @@
// Types, codes and constants of the channel server lookup table.
// Used by every module of the block but cslt_ram; depends on nothing.
package cslt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 8;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_EXPIRY = 2'd1,
    MODE_SERVER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SERVER = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_FALLBACK  = 2'd0,
    CFG_OVR_EN    = 2'd1,
    CFG_OVR_ADDR  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ADDR_W-1:0] server;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] group;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic fetch;
    logic check;
    logic next;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic count_zero;
    logic match;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/cslt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the table entries of the lookup table.
module cslt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cslt_dp.sv @@
// Datapath: item and configuration registers, entry RAM, key compare and result register.
// Depends on cslt_pkg, cslt_ram and the assertion macro header.
`include "channel_server_lookup_table_assert.svh"
module cslt_dp #(
  parameter int unsigned TABLE_DEPTH = cslt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cslt_pkg::ctrl_cmd_t             cmd_i,
  output cslt_pkg::dp_status_t            status_o,
  input  logic [1:0]                      s_tuser_i,
  input  logic [cslt_pkg::S_TDATA_W-1:0]  s_tdata_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [cslt_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic                            m_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [cslt_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [cslt_pkg::ADDR_W-1:0]     cfg_wdata_i
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  cslt_pkg::mode_e             mode_q;
  logic [cslt_pkg::ADDR_W-1:0] group_q;
  logic [cslt_pkg::PORT_W-1:0] port_q;
  logic [cslt_pkg::ADDR_W-1:0] value_q;
  logic [cslt_pkg::TIME_W-1:0] now_q;

  logic [cslt_pkg::ADDR_W-1:0] fallback_q;
  logic                        ovr_en_q;
  logic [cslt_pkg::ADDR_W-1:0] ovr_addr_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             hit_q, hit_d;

  logic                         out_valid_q, out_valid_d;
  logic [cslt_pkg::ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic                         out_src_q, out_src_d;
  cslt_pkg::status_e            out_status_q, out_status_d;

  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  cslt_pkg::entry_t               mem_wdata;
  logic [cslt_pkg::ENTRY_W-1:0]   mem_rdata;
  cslt_pkg::entry_t               rd_entry;
  logic                           wr_req;
  logic                           count_inc;
  logic                           expired;
  logic                           full;

  // hold the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= cslt_pkg::mode_e'(s_tuser_i);
      group_q <= s_tdata_i[31:0];
      port_q  <= s_tdata_i[47:32];
      value_q <= s_tdata_i[79:48];
      now_q   <= s_tdata_i[111:80];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= '0;
      ovr_en_q   <= 1'b0;
      ovr_addr_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == cslt_pkg::CFG_FALLBACK) begin
        fallback_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == cslt_pkg::CFG_OVR_EN) begin
        ovr_en_q <= cfg_wdata_i[0];
      end
      if (cfg_addr_i == cslt_pkg::CFG_OVR_ADDR) begin
        ovr_addr_q <= cfg_wdata_i;
      end
    end
  end

  cslt_ram #(
    .WIDTH (cslt_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.fetch),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign rd_entry = cslt_pkg::entry_t'(mem_rdata);
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign expired  = hit_q && (rd_entry.server != '0) && (rd_entry.expiry != '0) &&
                    (rd_entry.expiry <= now_q);

  assign status_o.need_scan  = ((mode_q == cslt_pkg::MODE_LOOKUP) && !ovr_en_q) ||
                               (mode_q == cslt_pkg::MODE_EXPIRY) ||
                               (mode_q == cslt_pkg::MODE_SERVER);
  assign status_o.count_zero = (count_q == '0);
  assign status_o.match      = (rd_entry.group == group_q) && (rd_entry.port == port_q);
  assign status_o.last       = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign status_o.out_free   = !out_valid_q || m_tready_i;

  always_comb begin
    wr_req       = 1'b0;
    count_inc    = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_entry;
    out_addr_d   = '0;
    out_src_d    = 1'b0;
    out_status_d = cslt_pkg::STATUS_OK;
    unique case (mode_q)
      cslt_pkg::MODE_LOOKUP: begin
        if (ovr_en_q) begin
          out_addr_d = ovr_addr_q;
          if (ovr_addr_q == '0) begin
            out_status_d = cslt_pkg::STATUS_NO_SERVER;
          end
        end else begin
          wr_req           = expired;
          mem_wdata.server = '0;
          if (hit_q && (rd_entry.server != '0) && !expired) begin
            out_addr_d = rd_entry.server;
            out_src_d  = 1'b1;
          end else if (fallback_q != '0) begin
            out_addr_d = fallback_q;
          end else begin
            out_status_d = cslt_pkg::STATUS_NO_SERVER;
          end
        end
      end
      cslt_pkg::MODE_EXPIRY, cslt_pkg::MODE_SERVER: begin
        if (!hit_q) begin
          mem_waddr        = count_q[IDX_W-1:0];
          mem_wdata.group  = group_q;
          mem_wdata.port   = port_q;
          mem_wdata.server = '0;
          mem_wdata.expiry = '0;
        end
        if (mode_q == cslt_pkg::MODE_EXPIRY) begin
          mem_wdata.expiry = value_q;
        end else begin
          mem_wdata.server = value_q;
        end
        if (hit_q) begin
          wr_req = 1'b1;
        end else if (full) begin
          out_status_d = cslt_pkg::STATUS_FULL;
        end else begin
          wr_req    = 1'b1;
          count_inc = 1'b1;
        end
      end
      cslt_pkg::MODE_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign mem_we = cmd_i.commit && wr_req;

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    if (cmd_i.commit && count_inc) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.load) begin
      idx_d = '0;
      hit_d = 1'b0;
    end else if (cmd_i.next) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.check && status_o.match) begin
      hit_d = 1'b1;
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_addr_q   <= out_addr_d;
      out_src_q    <= out_src_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b0, out_status_q, out_addr_q};
  assign m_tuser_o  = out_src_q;

  `CSLT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(TABLE_DEPTH),
                     "fill count beyond table depth")
  `CSLT_ASSERT(a_count_on_commit, clk_i, rst_ni, !cmd_i.commit |=> $stable(count_q),
               "fill count moved without a commit")
  `CSLT_ASSERT(a_commit_free, clk_i, rst_ni, cmd_i.commit |-> status_o.out_free,
               "result overwritten before it was taken")
  `CSLT_ASSERT_NEVER(a_full_insert, clk_i, rst_ni, mem_we && count_inc && full,
                     "insert into a full table")

endmodule

@@ rtl/cslt_ctrl.sv @@
// Controller state machine: sequences item capture, key scan and commit.
// Depends on cslt_pkg and the assertion macro header.
`include "channel_server_lookup_table_assert.svh"
module cslt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cslt_pkg::dp_status_t status_i,
  output cslt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_FETCH  = 5'b00100,
    S_CHECK  = 5'b01000,
    S_UPDATE = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.need_scan && !status_i.count_zero) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        priority if (status_i.match || status_i.last) begin
          state_d = S_UPDATE;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  `CSLT_ASSERT(a_accept_decode, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> state_q == S_DECODE,
               "accepted item not decoded")
  `CSLT_ASSERT(a_fetch_check, clk_i, rst_ni, cmd_o.fetch |=> cmd_o.check,
               "entry read not followed by compare")
  `CSLT_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q),
               "controller state not one-hot")

endmodule

@@ rtl/channel_server_lookup_table.sv @@
// Top level of the channel server lookup table: controller plus datapath.
// Depends on cslt_pkg, cslt_ctrl, cslt_dp and cslt_ram.
//
// Channel  Direction  tdata (low bit up)                          tuser
// s_axis   in         group_addr, group_port, value, now_ms      mode
// m_axis   out        server_addr, status, zero pad               source
// cfg      in         index 0 fallback, 1 override enable, 2 override address
//
// An item holds the input, acceptance to next acceptance, through the idle, decode and update
// states when no scan is needed (override lookup, unused mode, empty table), plus a fetch and
// a check state per entry when the key search reads k entries of the entry RAM, one read and
// one compare each, up to the fill count. The commit loads the result; the next item can follow
// in the cycle after. A stalled output holds the commit; reset empties the table at once.
module channel_server_lookup_table #(
  parameter int unsigned TABLE_DEPTH = cslt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cslt_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // group_addr, group_port, value, now_ms
  input  logic [1:0]                      s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cslt_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // server_addr, status, zero pad
  output logic                            m_axis_tuser,  // source
  input  logic                            cfg_we_i,
  input  logic [cslt_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [cslt_pkg::ADDR_W-1:0]     cfg_wdata_i
);

  cslt_pkg::ctrl_cmd_t  cmd;
  cslt_pkg::dp_status_t dp_status;

  cslt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  cslt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

@@ test/tb_channel_server_lookup_table.sv @@
// Self-checking bench for channel_server_lookup_table: directed and random items
// through the stream ports, checked against an in-bench model of the server table.
// Depends on cslt_pkg and the RTL of the block only.
module tb_channel_server_lookup_table;
  import cslt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned SLOTS = TABLE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 3 + 2 * SLOTS + 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 210;

  typedef struct {
    mode_e             mode;
    logic [ADDR_W-1:0] group;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] value;
    logic [TIME_W-1:0] now;
  } chan_req_t;

  typedef struct {
    logic [ADDR_W-1:0] server;
    logic              source;
    status_e           status;
  } chan_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [ADDR_W-1:0]     cfg_wdata_i = '0;

  // model of the server table and its registers
  logic              slot_used   [SLOTS];
  logic [ADDR_W-1:0] slot_group  [SLOTS];
  logic [PORT_W-1:0] slot_port   [SLOTS];
  logic [ADDR_W-1:0] slot_server [SLOTS];
  logic [TIME_W-1:0] slot_expiry [SLOTS];
  logic [ADDR_W-1:0] fb_addr = '0;
  logic              ovr_on = 1'b0;
  logic [ADDR_W-1:0] ovr_addr = '0;

  chan_req_t   pending_reqs[$];
  chan_res_t   due_replies[$];
  chan_req_t   held_req;
  chan_res_t   want;
  int          open_reqs = 0;
  int          error_count = 0;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 70;
  int unsigned quiet_cycles = 0;
  logic [ADDR_W-1:0] key_group [SLOTS];
  logic [PORT_W-1:0] key_port  [SLOTS];
  logic [TIME_W-1:0] wall_ms;

  channel_server_lookup_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // group_addr, group_port, value, now_ms
    .s_axis_tuser  (s_axis_tuser),  // mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // server_addr, status, zero pad
    .m_axis_tuser  (m_axis_tuser),  // source
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic chan_res_t resolve_server(chan_req_t rq);
    chan_res_t         rs;
    int                hit;
    logic [ADDR_W-1:0] srv;
    rs.server = '0;
    rs.source = 1'b0;
    rs.status = STATUS_OK;
    hit = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_group[i] == rq.group && slot_port[i] == rq.port) begin
        hit = i;
      end
    end
    case (rq.mode)
      MODE_LOOKUP: begin
        if (ovr_on) begin
          if (ovr_addr != '0) rs.server = ovr_addr;
          else rs.status = STATUS_NO_SERVER;
        end else begin
          srv = '0;
          if (hit >= 0) begin
            srv = slot_server[hit];
            if (srv != '0 && slot_expiry[hit] != '0 && slot_expiry[hit] <= rq.now) begin
              slot_server[hit] = '0;
              srv = '0;
            end
          end
          if (srv != '0) begin
            rs.server = srv;
            rs.source = 1'b1;
          end else if (fb_addr != '0) begin
            rs.server = fb_addr;
          end else begin
            rs.status = STATUS_NO_SERVER;
          end
        end
      end
      MODE_EXPIRY, MODE_SERVER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && !slot_used[i]) begin
            slot_used[i]   = 1'b1;
            slot_group[i]  = rq.group;
            slot_port[i]   = rq.port;
            slot_server[i] = '0;
            slot_expiry[i] = '0;
            hit = i;
          end
        end
        if (hit < 0) rs.status = STATUS_FULL;
        else if (rq.mode == MODE_EXPIRY) slot_expiry[hit] = rq.value;
        else slot_server[hit] = rq.value;
      end
      default: ;
    endcase
    return rs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_replies.push_back(resolve_server(held_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {held_req.now, held_req.value, held_req.port, held_req.group};
          s_axis_tuser  <= held_req.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_replies.size() == 0) begin
          $error("item out with no request outstanding");
          error_count++;
        end else begin
          want = due_replies.pop_front();
          open_reqs--;
          if (m_axis_tdata[ADDR_W-1:0] !== want.server) begin
            $error("server_addr expected %h got %h", want.server, m_axis_tdata[ADDR_W-1:0]);
            error_count++;
          end
          if (m_axis_tdata[ADDR_W+1:ADDR_W] !== want.status) begin
            $error("status expected %0d got %0d", want.status, m_axis_tdata[ADDR_W+1:ADDR_W]);
            error_count++;
          end
          if (m_axis_tdata[M_TDATA_W-1:ADDR_W+2] !== '0) begin
            $error("pad expected 0 got %h", m_axis_tdata[M_TDATA_W-1:ADDR_W+2]);
            error_count++;
          end
          if (m_axis_tuser !== want.source) begin
            $error("source expected %0d got %0d", want.source, m_axis_tuser);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_req(input mode_e md, input logic [ADDR_W-1:0] grp,
                          input logic [PORT_W-1:0] prt, input logic [ADDR_W-1:0] val,
                          input logic [TIME_W-1:0] now);
    chan_req_t rq;
    rq.mode  = md;
    rq.group = grp;
    rq.port  = prt;
    rq.value = val;
    rq.now   = now;
    open_reqs++;
    pending_reqs.push_back(rq);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_FALLBACK: fb_addr = data;
      CFG_OVR_EN:   ovr_on = data[0];
      CFG_OVR_ADDR: ovr_addr = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (open_reqs != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_random_item();
    int unsigned       k;
    int unsigned       pick;
    mode_e             md;
    logic [ADDR_W-1:0] grp;
    logic [PORT_W-1:0] prt;
    logic [ADDR_W-1:0] val;
    logic [TIME_W-1:0] now;
    k   = $urandom_range(SLOTS - 1);
    grp = key_group[k];
    prt = key_port[k];
    if ($urandom_range(99) < 15) begin
      grp = $urandom;
      prt = PORT_W'($urandom_range(16'hFFFF));
    end
    val  = $urandom;
    pick = $urandom_range(99);
    if (pick < 45) begin
      md = MODE_LOOKUP;
    end else if (pick < 65) begin
      md = MODE_EXPIRY;
      pick = $urandom_range(9);
      if (pick < 2) val = '0;
      else if (pick > 2) val = wall_ms + $urandom_range(40);
    end else if (pick < 88) begin
      md = MODE_SERVER;
      if ($urandom_range(9) == 0) val = '0;
    end else begin
      md = MODE_NONE;
    end
    pick = $urandom_range(19);
    if (pick < 2) now = $urandom;
    else if (pick == 2) now = '1;
    else now = wall_ms;
    wall_ms = wall_ms + $urandom_range(3);
    push_req(md, grp, prt, val, now);
  endtask

  initial begin
    logic [ADDR_W-1:0] rnd_a;
    logic [ADDR_W-1:0] rnd_b;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]   = 1'b0;
      slot_group[i]  = '0;
      slot_port[i]   = '0;
      slot_server[i] = '0;
      slot_expiry[i] = '0;
      key_group[i]   = $urandom;
      key_port[i]    = PORT_W'($urandom_range(16'hFFFF));
    end
    key_group[0] = '0;  key_port[0] = '0;
    key_group[1] = '1;  key_port[1] = '1;
    key_group[2] = '0;  key_port[2] = '1;
    key_group[3] = '1;  key_port[3] = '0;
    wall_ms = $urandom;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, no fallback, unused mode
    push_req(MODE_LOOKUP, key_group[0], key_port[0], '0, '0);
    push_req(MODE_NONE, '1, '1, '1, '1);
    // insert by server write; zero expiry never expires
    push_req(MODE_SERVER, key_group[0], key_port[0], '1, '0);
    push_req(MODE_LOOKUP, key_group[0], key_port[0], '0, '0);
    // expiry boundary, then the cleared entry stays cleared
    push_req(MODE_EXPIRY, key_group[0], key_port[0], 32'd100, '0);
    push_req(MODE_LOOKUP, key_group[0], key_port[0], '0, 32'd99);
    push_req(MODE_LOOKUP, key_group[0], key_port[0], '0, 32'd100);
    push_req(MODE_LOOKUP, key_group[0], key_port[0], '0, '0);
    // insert by expiry write; a zero server is never cleared
    push_req(MODE_EXPIRY, key_group[1], key_port[1], '1, '0);
    push_req(MODE_LOOKUP, key_group[1], key_port[1], '0, '1);
    push_req(MODE_SERVER, key_group[1], key_port[1], 32'd1, '0);
    push_req(MODE_LOOKUP, key_group[1], key_port[1], '0, 32'hFFFF_FFFE);
    push_req(MODE_LOOKUP, key_group[1], key_port[1], '0, '1);
    // fill the table, then overflow it
    for (int i = 2; i < SLOTS; i++) push_req(MODE_SERVER, key_group[i], key_port[i], $urandom, '0);
    push_req(MODE_LOOKUP, key_group[2], key_port[2], '0, '0);
    push_req(MODE_SERVER, 32'd1, '0, '1, '0);
    push_req(MODE_EXPIRY, 32'd1, '0, '1, '0);
    push_req(MODE_LOOKUP, 32'd1, '0, '0, '0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 10; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      rnd_a = $urandom;
      rnd_b = $urandom;
      case (ph)
        0: begin write_reg(CFG_FALLBACK, '1);    write_reg(CFG_OVR_EN, '0); write_reg(CFG_OVR_ADDR, '0); end
        1: begin write_reg(CFG_FALLBACK, rnd_a); write_reg(CFG_OVR_EN, '1); end
        2: begin write_reg(CFG_FALLBACK, '0);    write_reg(CFG_OVR_ADDR, '1); end
        3: begin write_reg(CFG_OVR_EN, '0);      write_reg(CFG_OVR_ADDR, rnd_b); end
        4: begin write_reg(CFG_FALLBACK, rnd_a); write_reg(CFG_OVR_EN, '1); end
        5: begin write_reg(CFG_FALLBACK, 32'd1); write_reg(CFG_OVR_EN, '0); write_reg(CFG_OVR_ADDR, '0); end
        6: begin write_reg(CFG_FALLBACK, rnd_a); write_reg(CFG_OVR_ADDR, rnd_b); end
        7: begin write_reg(CFG_FALLBACK, '0);    write_reg(CFG_OVR_EN, '1); write_reg(CFG_OVR_ADDR, '0); end
        default: begin write_reg(CFG_FALLBACK, rnd_a); write_reg(CFG_OVR_EN, '0); write_reg(CFG_OVR_ADDR, '1); end
      endcase
      write_reg(CFG_SPARE, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) add_random_item();
      drain();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
